// File: design/dtd_pkg.sv
// Shared types and constants for the debounced trough detector.
`default_nettype none

package dtd_pkg;

	// Widths fixed by the register map and the result format
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 16;
	localparam int THR_W      = 16;
	localparam int LIMIT_W    = 4;
	localparam int HYST_W     = 15;
	localparam int IDX_W      = 10;

	// Register indexes of the configuration port
	localparam logic [CFG_IDX_W-1:0] REG_FALL_THRESHOLD   = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_DEBOUNCE_LIMIT   = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_NOISE_HYSTERESIS = 2'd2;
	localparam logic [CFG_IDX_W-1:0] REG_SEED_FROM_FIRST  = 2'd3;

	// Reset values: -0.03, 2 rises, 0.002, seed with zero
	localparam logic signed [THR_W-1:0] FALL_THRESHOLD_RST   = -16'sd983;
	localparam logic [LIMIT_W-1:0]      DEBOUNCE_LIMIT_RST   = 4'd2;
	localparam logic [HYST_W-1:0]       NOISE_HYSTERESIS_RST = 15'd66;
	localparam logic                    SEED_FROM_FIRST_RST  = 1'b0;

	// Rise count saturates here
	localparam logic [LIMIT_W-1:0] RISE_MAX = 4'd15;

	typedef struct packed {
		logic signed [THR_W-1:0] fall_threshold;
		logic [LIMIT_W-1:0]      debounce_limit;
		logic [HYST_W-1:0]       noise_hysteresis;
		logic                    seed_from_first;
	} dtd_cfg_t;

endpackage

`default_nettype wire

// File: design/dtd_stream_if.sv
// Valid/ready channels for sample items and result items.
`default_nettype none

interface dtd_in_if #(parameter int SAMPLE_BITS = 16);
	logic                          valid;
	logic                          ready;
	logic signed [SAMPLE_BITS-1:0] sample;
	logic                          window_start;
	logic                          window_end;

	modport source (output valid, sample, window_start, window_end, input ready);
	modport sink (input valid, sample, window_start, window_end, output ready);
endinterface

interface dtd_out_if #(parameter int SAMPLE_BITS = 16);
	logic                          valid;
	logic                          ready;
	logic                          found;
	logic [9:0]                    trough_index;
	logic signed [SAMPLE_BITS-1:0] trough_value;

	modport source (output valid, found, trough_index, trough_value, input ready);
	modport sink (input valid, found, trough_index, trough_value, output ready);
endinterface

`default_nettype wire

// File: design/debounced_trough_detector_top.sv
// Top level of the debounced trough detector: configuration, core and result register.
`default_nettype none

// Takes one sample item per clock on the samples channel and answers each window with one
// result item on the results channel, registered in the cycle after the window's last sample.
// An item is accepted in every cycle unless a finished result is held and not taken; the
// rate is set by the single output register. A result gives whether a trough was found, its
// offset from the window's first sample (low 10 bits) and its value; with no trough, the
// offset is 0 and the value is the seed (first sample or zero). Samples outside an open
// window are dropped. Write the configuration only while the block is idle.
module debounced_trough_detector_top import dtd_pkg::*; #(
	parameter int MAX_WINDOW  = 1024,
	parameter int SAMPLE_BITS = 16
) (
	input  logic                  clk,
	input  logic                  arst_n,
	dtd_in_if.sink                samples,
	dtd_out_if.source             results,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_wdata
);

	dtd_cfg_t cfg_q;

	logic                          step;
	logic                          emit;
	logic                          found;
	logic [IDX_W-1:0]              index;
	logic signed [SAMPLE_BITS-1:0] value;

	logic                          res_valid_q;
	logic                          res_found_q;
	logic [IDX_W-1:0]              res_index_q;
	logic signed [SAMPLE_BITS-1:0] res_value_q;

	// Write configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.fall_threshold   <= FALL_THRESHOLD_RST;
			cfg_q.debounce_limit   <= DEBOUNCE_LIMIT_RST;
			cfg_q.noise_hysteresis <= NOISE_HYSTERESIS_RST;
			cfg_q.seed_from_first  <= SEED_FROM_FIRST_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_FALL_THRESHOLD:   cfg_q.fall_threshold   <= $signed(cfg_wdata[THR_W-1:0]);
				REG_DEBOUNCE_LIMIT:   cfg_q.debounce_limit   <= cfg_wdata[LIMIT_W-1:0];
				REG_NOISE_HYSTERESIS: cfg_q.noise_hysteresis <= cfg_wdata[HYST_W-1:0];
				REG_SEED_FROM_FIRST:  cfg_q.seed_from_first  <= cfg_wdata[0];
				default: ;
			endcase
		end
	end

	// Accept while the result register is empty or being emptied
	assign samples.ready = !res_valid_q || results.ready;
	assign step          = samples.valid && samples.ready;

	dtd_core #(
		.MAX_WINDOW  (MAX_WINDOW),
		.SAMPLE_BITS (SAMPLE_BITS)
	) u_core (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_q),
		.step      (step),
		.sample    (samples.sample),
		.win_start (samples.window_start),
		.win_end   (samples.window_end),
		.emit      (emit),
		.found     (found),
		.index     (index),
		.value     (value)
	);

	// Hold the result until taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (emit) begin
			res_valid_q <= 1'b1;
		end else if (results.ready) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			res_found_q <= found;
			res_index_q <= index;
			res_value_q <= value;
		end
	end

	assign results.valid        = res_valid_q;
	assign results.found        = res_found_q;
	assign results.trough_index = res_index_q;
	assign results.trough_value = res_value_q;

`ifndef ASSERT_OFF
	// A window without a trough reports offset zero
	a_no_trough_index: assert property (@(posedge clk) disable iff (!arst_n)
		(results.valid && !results.found) |-> (results.trough_index == '0))
		else $error("result without trough carries a nonzero offset");

	// A one-sample window answers in the next cycle, with nothing found
	a_single_sample: assert property (@(posedge clk) disable iff (!arst_n)
		(step && samples.window_start && samples.window_end)
		|=> (results.valid && !results.found))
		else $error("one-sample window did not give an empty result");

	// A sample that does not close a window produces no new result
	a_open_no_result: assert property (@(posedge clk) disable iff (!arst_n)
		(step && !samples.window_end && !(res_valid_q && !results.ready))
		|=> !results.valid)
		else $error("result appeared without a window end");
`endif

endmodule

`default_nettype wire

// File: design/dtd_core.sv
// Search state and per-sample update of the trough detector.
`default_nettype none

module dtd_core import dtd_pkg::*; #(
	parameter int MAX_WINDOW  = 1024,
	parameter int SAMPLE_BITS = 16
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  dtd_cfg_t                      cfg,
	input  logic                          step,
	input  logic signed [SAMPLE_BITS-1:0] sample,
	input  logic                          win_start,
	input  logic                          win_end,
	output logic                          emit,
	output logic                          found,
	output logic [IDX_W-1:0]              index,
	output logic signed [SAMPLE_BITS-1:0] value
);

	localparam int PW = (MAX_WINDOW > 2) ? $clog2(MAX_WINDOW) : 1;
	localparam int IW = (PW > IDX_W) ? PW : IDX_W;
	localparam int AW = ((SAMPLE_BITS > THR_W) ? SAMPLE_BITS : THR_W) + 2;
	localparam logic [PW-1:0] POS_LAST = PW'(MAX_WINDOW - 1);

	logic                          tracking_q, tracking_n;
	logic [LIMIT_W-1:0]            rise_q, rise_n;
	logic [PW-1:0]                 cand_idx_q, cand_idx_n;
	logic signed [SAMPLE_BITS-1:0] cand_val_q, cand_val_n;
	logic                          cand_valid_q, cand_valid_n;
	logic [PW-1:0]                 conf_idx_q, conf_idx_n;
	logic signed [SAMPLE_BITS-1:0] conf_val_q, conf_val_n;
	logic                          conf_found_q, conf_found_n;
	logic signed [SAMPLE_BITS-1:0] prev_q, prev_n;
	logic [PW-1:0]                 pos_q, pos_n;
	logic                          have_prev_q, have_prev_n;

	logic signed [AW-1:0] slope;
	logic signed [AW-1:0] rise_level;
	logic [PW-1:0]        res_pos;
	logic [IW-1:0]        res_pos_ext;

	// Slope to the next sample and the rise level above the candidate
	assign slope      = AW'(sample) - AW'(prev_q);
	assign rise_level = AW'(cand_val_q) + AW'($signed({1'b0, cfg.noise_hysteresis}));

	// Work out the state after this sample
	always_comb begin
		tracking_n   = tracking_q;
		rise_n       = rise_q;
		cand_idx_n   = cand_idx_q;
		cand_val_n   = cand_val_q;
		cand_valid_n = cand_valid_q;
		conf_idx_n   = conf_idx_q;
		conf_val_n   = conf_val_q;
		conf_found_n = conf_found_q;
		prev_n       = prev_q;
		pos_n        = pos_q;
		have_prev_n  = (win_start || have_prev_q) && !win_end;
		if (win_start) begin
			tracking_n   = 1'b0;
			rise_n       = '0;
			cand_idx_n   = '0;
			cand_val_n   = '0;
			cand_valid_n = 1'b0;
			conf_idx_n   = '0;
			conf_val_n   = cfg.seed_from_first ? sample : '0;
			conf_found_n = 1'b0;
			prev_n       = sample;
			pos_n        = '0;
		end else if (have_prev_q) begin
			if (!tracking_q) begin
				if (slope < AW'(cfg.fall_threshold)) begin
					cand_idx_n   = pos_q;
					cand_val_n   = prev_q;
					cand_valid_n = 1'b1;
					rise_n       = '0;
					tracking_n   = 1'b1;
				end
			end else begin
				if (prev_q < cand_val_q && prev_q < conf_val_q) begin
					cand_idx_n = pos_q;
					cand_val_n = prev_q;
					rise_n     = '0;
				end else if (AW'(prev_q) > rise_level) begin
					if (rise_q != RISE_MAX) begin
						rise_n = rise_q + 1'b1;
					end
				end
				if (rise_n >= cfg.debounce_limit) begin
					conf_idx_n   = cand_idx_n;
					conf_val_n   = cand_val_n;
					conf_found_n = 1'b1;
					tracking_n   = 1'b0;
				end
			end
			if (pos_q != POS_LAST) begin
				pos_n = pos_q + 1'b1;
			end
			prev_n = sample;
		end
	end

	// Pick the confirmed trough, else the tracked one, else the seed
	always_comb begin
		emit    = step && win_end && (win_start || have_prev_q);
		found   = conf_found_n || cand_valid_n;
		res_pos = '0;
		value   = conf_val_n;
		if (conf_found_n) begin
			res_pos = conf_idx_n;
		end else if (cand_valid_n) begin
			res_pos = cand_idx_n;
			value   = cand_val_n;
		end
	end

	assign res_pos_ext = IW'(res_pos);
	assign index       = res_pos_ext[IDX_W-1:0];

	// Advance the state on every accepted item
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tracking_q   <= 1'b0;
			rise_q       <= '0;
			cand_idx_q   <= '0;
			cand_val_q   <= '0;
			cand_valid_q <= 1'b0;
			conf_idx_q   <= '0;
			conf_val_q   <= '0;
			conf_found_q <= 1'b0;
			prev_q       <= '0;
			pos_q        <= '0;
			have_prev_q  <= 1'b0;
		end else if (step) begin
			tracking_q   <= tracking_n;
			rise_q       <= rise_n;
			cand_idx_q   <= cand_idx_n;
			cand_val_q   <= cand_val_n;
			cand_valid_q <= cand_valid_n;
			conf_idx_q   <= conf_idx_n;
			conf_val_q   <= conf_val_n;
			conf_found_q <= conf_found_n;
			prev_q       <= prev_n;
			pos_q        <= pos_n;
			have_prev_q  <= have_prev_n;
		end
	end

endmodule

`default_nettype wire

// File: tb/sv/tb_debounced_trough_detector_top.sv
// Testbench for the debounced trough detector: random sample windows checked against a predictor.
module tb_debounced_trough_detector_top;
	import dtd_pkg::*;

	localparam int WATCHDOG_LIMIT = 4000;
	localparam int SETTLE_CYCLES  = 8;
	localparam int LONG_STALL     = 400;
	localparam logic [IDX_W-1:0] POS_MAX = 10'd1023;

	typedef struct {
		logic signed [15:0] sample;
		logic               win_start;
		logic               win_end;
		bit                 drain_first;
	} sample_item_t;

	typedef struct {
		logic               found;
		logic [IDX_W-1:0]   trough_index;
		logic signed [15:0] trough_value;
	} trough_result_t;

	logic                  clk;
	logic                  arst_n;
	logic                  cfg_we;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_DATA_W-1:0] cfg_wdata;

	dtd_in_if  samples_ch ();
	dtd_out_if results_ch ();

	debounced_trough_detector_top uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.samples   (samples_ch),
		.results   (results_ch),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata)
	);

	sample_item_t   pending_items[$];
	trough_result_t expected_troughs[$];
	int  items_queued   = 0;
	int  items_accepted = 0;
	int  results_taken  = 0;
	int  fail_count     = 0;
	int  idle_cycles    = 0;
	int  in_gap         = 0;
	int  out_gap        = 0;
	int  stall_left     = 0;
	bit  long_stall_done = 1'b0;
	bit  quiet          = 1'b0;
	logic in_taken      = 1'b0;

	// Predictor copy of the configuration and the detector state
	dtd_cfg_t           cfg_model;
	bit                 trk       = 1'b0;
	bit                 cand_ok   = 1'b0;
	bit                 conf_ok   = 1'b0;
	bit                 win_open  = 1'b0;
	logic [LIMIT_W-1:0] rises     = '0;
	logic [IDX_W-1:0]   cand_idx  = '0;
	logic [IDX_W-1:0]   conf_idx  = '0;
	logic [IDX_W-1:0]   pos       = '0;
	logic signed [15:0] cand_val  = '0;
	logic signed [15:0] conf_val  = '0;
	logic signed [15:0] prev_val  = '0;

	// Examine one sample against its next neighbour
	function automatic void track_step(logic signed [15:0] cur, logic signed [15:0] nxt);
		if (!trk) begin
			if (int'(nxt) - int'(cur) < int'(cfg_model.fall_threshold)) begin
				cand_idx = pos;
				cand_val = cur;
				cand_ok  = 1'b1;
				rises    = '0;
				trk      = 1'b1;
			end
		end else begin
			if (cur < cand_val && cur < conf_val) begin
				cand_idx = pos;
				cand_val = cur;
				rises    = '0;
			end else if (int'(cur) > int'(cand_val) + int'(cfg_model.noise_hysteresis)) begin
				if (rises < RISE_MAX)
					rises++;
			end
			if (rises >= cfg_model.debounce_limit) begin
				conf_idx = cand_idx;
				conf_val = cand_val;
				conf_ok  = 1'b1;
				trk      = 1'b0;
			end
		end
	endfunction

	// Advance the predictor by one accepted sample item; queue the window's trough on its end
	function automatic void predict_trough(logic signed [15:0] s, logic ws, logic we);
		trough_result_t r;
		if (ws || win_open) begin
			if (ws) begin
				trk      = 1'b0;
				rises    = '0;
				cand_idx = '0;
				cand_val = '0;
				cand_ok  = 1'b0;
				conf_idx = '0;
				conf_val = cfg_model.seed_from_first ? s : 16'sd0;
				conf_ok  = 1'b0;
				prev_val = s;
				pos      = '0;
				win_open = 1'b1;
			end else begin
				track_step(prev_val, s);
				if (pos < POS_MAX)
					pos++;
				prev_val = s;
			end
			if (we) begin
				r.found        = conf_ok;
				r.trough_index = conf_idx;
				r.trough_value = conf_val;
				if (!conf_ok && cand_ok) begin
					r.found        = 1'b1;
					r.trough_index = cand_idx;
					r.trough_value = cand_val;
				end
				if (!r.found)
					r.trough_index = '0;
				expected_troughs.push_back(r);
				win_open = 1'b0;
			end
		end
	endfunction

	// Clock
	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	// Reset and known values on every channel input
	initial begin
		arst_n                  = 1'b0;
		samples_ch.valid        = 1'b0;
		samples_ch.sample       = '0;
		samples_ch.window_start = 1'b0;
		samples_ch.window_end   = 1'b0;
		results_ch.ready        = 1'b0;
		repeat (11) @(negedge clk);
		arst_n <= 1'b1;
	end

	// Sample driver: offer pending items, with random gaps
	always @(negedge clk) begin
		sample_item_t it;
		if (!arst_n) begin
			samples_ch.valid <= 1'b0;
		end else if (in_taken || !samples_ch.valid) begin
			if (in_gap > 0) begin
				in_gap--;
				samples_ch.valid <= 1'b0;
			end else if (!quiet && $urandom_range(0, 9) == 0) begin
				in_gap = $urandom_range(1, 16) - 1;
				samples_ch.valid <= 1'b0;
			end else if (pending_items.size() > 0 &&
					(!pending_items[0].drain_first || expected_troughs.size() == 0)) begin
				it = pending_items.pop_front();
				samples_ch.sample       <= it.sample;
				samples_ch.window_start <= it.win_start;
				samples_ch.window_end   <= it.win_end;
				samples_ch.valid        <= 1'b1;
			end else begin
				samples_ch.valid <= 1'b0;
			end
		end
	end

	// Result receiver: random stalls and one long hold-off
	always @(negedge clk) begin
		if (!arst_n) begin
			results_ch.ready <= 1'b0;
		end else if (stall_left > 0) begin
			stall_left--;
			results_ch.ready <= 1'b0;
		end else if (!long_stall_done && results_taken >= 8) begin
			long_stall_done = 1'b1;
			stall_left = LONG_STALL - 1;
			results_ch.ready <= 1'b0;
		end else if (out_gap > 0) begin
			out_gap--;
			results_ch.ready <= 1'b0;
		end else if (!quiet && $urandom_range(0, 7) == 0) begin
			out_gap = $urandom_range(1, 16) - 1;
			results_ch.ready <= 1'b0;
		end else begin
			results_ch.ready <= 1'b1;
		end
	end

	// Monitor: check results, predict from accepted samples, watch for a hang
	always @(posedge clk) begin
		trough_result_t want;
		in_taken <= samples_ch.valid && samples_ch.ready;
		if (arst_n) begin
			if (results_ch.valid && results_ch.ready) begin
				results_taken++;
				if (expected_troughs.size() == 0) begin
					$error("unexpected result item: found %0d index %0d value %0d",
						results_ch.found, results_ch.trough_index, results_ch.trough_value);
					fail_count++;
				end else begin
					want = expected_troughs.pop_front();
					if (results_ch.found !== want.found) begin
						$error("found: expected %0d, got %0d", want.found, results_ch.found);
						fail_count++;
					end
					if (results_ch.trough_index !== want.trough_index) begin
						$error("trough_index: expected %0d, got %0d",
							want.trough_index, results_ch.trough_index);
						fail_count++;
					end
					if (results_ch.trough_value !== want.trough_value) begin
						$error("trough_value: expected %0d, got %0d",
							want.trough_value, results_ch.trough_value);
						fail_count++;
					end
				end
			end
			if (samples_ch.valid && samples_ch.ready) begin
				items_accepted++;
				predict_trough(samples_ch.sample, samples_ch.window_start, samples_ch.window_end);
			end
			if ((samples_ch.valid && samples_ch.ready) || (results_ch.valid && results_ch.ready))
				idle_cycles = 0;
			else
				idle_cycles++;
			if (idle_cycles >= WATCHDOG_LIMIT) begin
				$display("debounced_trough_detector_top test failed");
				$finish;
			end
		end
	end

	task automatic push_item(logic signed [15:0] s, logic ws, logic we, bit drain);
		sample_item_t it;
		it.sample      = s;
		it.win_start   = ws;
		it.win_end     = we;
		it.drain_first = drain;
		pending_items.push_back(it);
		items_queued++;
	endtask

	// Queue one window; shaped troughs, small noise or full-range samples
	task automatic queue_window(int len, bit drain, bit closed);
		int style;
		int level;
		int period;
		int fall_len;
		style    = $urandom_range(0, 3);
		period   = $urandom_range(4, 12);
		fall_len = $urandom_range(1, 3);
		level    = int'($urandom_range(0, 40000)) - 8000;
		for (int k = 0; k < len; k++) begin
			case (style)
				0: begin
					if ($urandom_range(0, 3) == 0)
						level = $urandom_range(0, 1) ? 32767 : -32768;
					else
						level = int'($urandom_range(0, 65535)) - 32768;
				end
				3: level = level + int'($urandom_range(0, 200)) - 100;
				default: begin
					if ((k % period) < fall_len)
						level = level - int'($urandom_range(0, 6000));
					else
						level = level + int'($urandom_range(0, 500)) - 60;
				end
			endcase
			if (level > 32767)
				level = 32767;
			if (level < -32768)
				level = -32768;
			push_item(level[15:0], k == 0, closed && (k == len - 1), drain && (k == 0));
		end
	endtask

	// Mostly well-formed windows, with stray samples, abandoned and one-sample windows
	task automatic queue_random(int n_items);
		int added;
		int pick;
		int len;
		added = 0;
		while (added < n_items) begin
			pick = $urandom_range(0, 19);
			if (pick < 16) begin
				len = $urandom_range(2, 24);
				queue_window(len, $urandom_range(0, 19) == 0, 1'b1);
				added += len;
			end else if (pick == 16) begin
				push_item(16'($urandom_range(0, 65535)), 1'b1, 1'b1, 1'b0);
				added++;
			end else if (pick == 17) begin
				// stray samples outside any window
				repeat ($urandom_range(1, 3))
					push_item(16'($urandom_range(0, 65535)), 1'b0, 1'($urandom_range(0, 1)), 1'b0);
			end else begin
				// window abandoned by the next start
				len = $urandom_range(1, 10);
				queue_window(len, 1'b0, 1'b0);
				added += len;
			end
		end
		queue_window($urandom_range(2, 12), 1'b0, 1'b1);
	endtask

	// Wait until every queued item is taken and every trough has come, then let the block settle
	task automatic wait_drained();
		do
			@(negedge clk);
		while (items_accepted != items_queued || expected_troughs.size() != 0);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	// Write all four registers, one after another, and mirror them in the predictor
	task automatic apply_config(logic signed [15:0] thr, logic [3:0] lim, logic [14:0] hyst,
			logic seed);
		logic [CFG_DATA_W-1:0] wdata [4];
		logic [CFG_IDX_W-1:0]  regs [4];
		regs  = '{REG_FALL_THRESHOLD, REG_DEBOUNCE_LIMIT, REG_NOISE_HYSTERESIS,
			REG_SEED_FROM_FIRST};
		wdata = '{CFG_DATA_W'(thr), CFG_DATA_W'(lim), CFG_DATA_W'(hyst), CFG_DATA_W'(seed)};
		for (int i = 0; i < 4; i++) begin
			@(negedge clk);
			cfg_we    <= 1'b1;
			cfg_index <= regs[i];
			cfg_wdata <= wdata[i];
			@(negedge clk);
			cfg_we <= 1'b0;
		end
		cfg_model.fall_threshold   = thr;
		cfg_model.debounce_limit   = lim;
		cfg_model.noise_hysteresis = hyst;
		cfg_model.seed_from_first  = seed;
	endtask

	// Stimulus
	initial begin
		cfg_we    = 1'b0;
		cfg_index = REG_FALL_THRESHOLD;
		cfg_wdata = '0;
		cfg_model.fall_threshold   = FALL_THRESHOLD_RST;
		cfg_model.debounce_limit   = DEBOUNCE_LIMIT_RST;
		cfg_model.noise_hysteresis = NOISE_HYSTERESIS_RST;
		cfg_model.seed_from_first  = SEED_FROM_FIRST_RST;
		@(posedge arst_n);

		// one-sample window: nothing examined, seed reported
		push_item(-32768, 1'b1, 1'b1, 1'b0);
		// stray sample with an end mark outside any window
		push_item(32767, 1'b0, 1'b1, 1'b0);
		// full-scale fall, new minimum, no confirmation before the end
		push_item(32767, 1'b1, 1'b0, 1'b0);
		push_item(-32768, 1'b0, 1'b0, 1'b0);
		push_item(-32768, 1'b0, 1'b0, 1'b0);
		push_item(32767, 1'b0, 1'b0, 1'b0);
		push_item(32767, 1'b0, 1'b1, 1'b0);
		// start inside a window abandons it; the next window confirms a trough
		push_item(1000, 1'b1, 1'b0, 1'b0);
		push_item(-2000, 1'b0, 1'b0, 1'b0);
		push_item(500, 1'b1, 1'b0, 1'b0);
		push_item(-600, 1'b0, 1'b0, 1'b0);
		push_item(-700, 1'b0, 1'b0, 1'b0);
		push_item(-500, 1'b0, 1'b0, 1'b0);
		push_item(0, 1'b0, 1'b0, 1'b0);
		push_item(200, 1'b0, 1'b1, 1'b0);
		// flat window: no trough
		push_item(0, 1'b1, 1'b0, 1'b0);
		push_item(0, 1'b0, 1'b0, 1'b0);
		push_item(0, 1'b0, 1'b1, 1'b0);
		push_item(123, 1'b0, 1'b0, 1'b0);
		wait_drained();

		queue_random(60);
		wait_drained();

		// extremes of every register
		apply_config(-16'sd32768, 4'd15, 15'd0, 1'b1);
		queue_random(40);
		wait_drained();
		apply_config(16'sd0, 4'd1, 15'd32767, 1'b0);
		queue_random(40);
		wait_drained();

		// debounce limit zero: first tracking step confirms at once
		apply_config(FALL_THRESHOLD_RST, 4'd0, NOISE_HYSTERESIS_RST, 1'b1);
		queue_random(40);
		wait_drained();

		for (int p = 0; p < 2; p++) begin
			apply_config(16'(-int'($urandom_range(0, 32768))), 4'($urandom_range(1, 15)),
				15'($urandom_range(0, 2000)), 1'($urandom_range(0, 1)));
			queue_random(30);
			wait_drained();
		end

		// long window: position saturates
		apply_config(-16'sd2000, 4'd3, 15'd100, 1'b1);
		queue_window(1040, 1'b0, 1'b1);
		wait_drained();

		// last stretch without idling
		quiet = 1'b1;
		apply_config(FALL_THRESHOLD_RST, DEBOUNCE_LIMIT_RST, NOISE_HYSTERESIS_RST,
			SEED_FROM_FIRST_RST);
		queue_random(40);
		wait_drained();

		if (fail_count == 0 && expected_troughs.size() == 0)
			$display("debounced_trough_detector_top test passed");
		else
			$display("debounced_trough_detector_top test failed");
		$finish;
	end

endmodule
